// File: src/nsfc_pkg.sv
// Shared types, character codes and register defaults of the NMEA sentence parser.
package nsfc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [3:0] HEX_TEN   = 4'd10;

    localparam int unsigned FIELD_W = 5;
    localparam logic [FIELD_W-1:0] FIELD_MAX   = 5'd31;
    localparam logic [FIELD_W-1:0] FIELD_FIRST = 5'd1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT = 3'd4;

    localparam logic [FIELD_W-1:0] RST_TIME   = 5'd2;
    localparam logic [FIELD_W-1:0] RST_LAT    = 5'd3;
    localparam logic [FIELD_W-1:0] RST_LON    = 5'd5;
    localparam logic [FIELD_W-1:0] RST_ALT    = 5'd10;
    localparam logic [FIELD_W-1:0] RST_EXPECT = 5'd15;

    localparam logic [1:0] FID_TIME = 2'd0;
    localparam logic [1:0] FID_LAT  = 2'd1;
    localparam logic [1:0] FID_LON  = 2'd2;
    localparam logic [1:0] FID_ALT  = 2'd3;

    localparam logic RES_CHAR   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        TOK_OTHER,
        TOK_DOLLAR,
        TOK_STAR,
        TOK_COMMA
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
        logic       hex_ok;
        logic [3:0] hex_val;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BODY,
        ST_CK_HI,
        ST_CK_LO
    } parse_state_t;

    typedef struct packed {
        logic               result_kind;
        logic [1:0]         field_id;
        logic [7:0]         field_char;
        logic               checksum_ok;
        logic [7:0]         computed_checksum;
        logic [7:0]         received_checksum;
        logic [FIELD_W-1:0] field_count;
        logic               count_ok;
    } result_t;

endpackage

// File: src/nsfc_ifs.sv
// Valid/ready channel interfaces for the sentence byte input and the result output.
interface nsfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfc_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [1:0] field_id;
    logic [7:0] field_char;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [4:0] field_count;
    logic       count_ok;

    modport source (
        output valid, output result_kind, output field_id, output field_char,
        output checksum_ok, output computed_checksum, output received_checksum,
        output field_count, output count_ok, input ready
    );
    modport sink (
        input valid, input result_kind, input field_id, input field_char,
        input checksum_ok, input computed_checksum, input received_checksum,
        input field_count, input count_ok, output ready
    );
endinterface

// File: src/nsfc_front.sv
// Front end: accepts sentence bytes and classifies them into tokens for the queue.
module nsfc_front (
    nsfc_rx_if.sink            rx_chan,
    input  nsfc_pkg::q_status_t q_stat,
    output logic               push,
    output nsfc_pkg::token_t   push_tok
);

    logic [7:0] c;

    assign c             = rx_chan.rx_byte;
    assign rx_chan.ready = !q_stat.full;
    assign push          = rx_chan.valid && !q_stat.full;

    always_comb
    begin
        push_tok.data    = c;
        push_tok.hex_ok  = 1'b0;
        push_tok.hex_val = 4'd0;
        priority if (c == nsfc_pkg::CH_DOLLAR)
        begin
            push_tok.kind = nsfc_pkg::TOK_DOLLAR;
        end
        else if (c == nsfc_pkg::CH_STAR)
        begin
            push_tok.kind = nsfc_pkg::TOK_STAR;
        end
        else if (c == nsfc_pkg::CH_COMMA)
        begin
            push_tok.kind = nsfc_pkg::TOK_COMMA;
        end
        else
        begin
            push_tok.kind = nsfc_pkg::TOK_OTHER;
        end

        priority if (c >= nsfc_pkg::CH_ZERO && c <= nsfc_pkg::CH_NINE)
        begin
            push_tok.hex_ok  = 1'b1;
            push_tok.hex_val = 4'(c - nsfc_pkg::CH_ZERO);
        end
        else if (c >= nsfc_pkg::CH_UP_A && c <= nsfc_pkg::CH_UP_F)
        begin
            push_tok.hex_ok  = 1'b1;
            push_tok.hex_val = 4'(c - nsfc_pkg::CH_UP_A) + nsfc_pkg::HEX_TEN;
        end
        else if (c >= nsfc_pkg::CH_LOW_A && c <= nsfc_pkg::CH_LOW_F)
        begin
            push_tok.hex_ok  = 1'b1;
            push_tok.hex_val = 4'(c - nsfc_pkg::CH_LOW_A) + nsfc_pkg::HEX_TEN;
        end
        else
        begin
            push_tok.hex_ok  = 1'b0;
            push_tok.hex_val = 4'd0;
        end
    end

endmodule

// File: src/nsfc_queue.sv
// Two-entry token queue that decouples the front end from the parser.
module nsfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nsfc_pkg::token_t    push_tok,
    input  logic                pop,
    output nsfc_pkg::token_t    pop_tok,
    output nsfc_pkg::q_status_t q_stat
);

    nsfc_pkg::token_t                mem_reg [nsfc_pkg::Q_DEPTH];
    logic [nsfc_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [nsfc_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [nsfc_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [nsfc_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [nsfc_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic [nsfc_pkg::Q_CNT_W-1:0]    cnt_next;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == nsfc_pkg::Q_CNT_W'(nsfc_pkg::Q_DEPTH));
    assign pop_tok      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// File: src/nsfc_back.sv
// Back end: configuration registers, sentence state machine and output register.
module nsfc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nsfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  nsfc_pkg::q_status_t               q_stat,
    input  nsfc_pkg::token_t                  pop_tok,
    output logic                              pop,
    nsfc_res_if.source                        res_chan
);

    logic [nsfc_pkg::FIELD_W-1:0] cfg_time_reg;
    logic [nsfc_pkg::FIELD_W-1:0] cfg_lat_reg;
    logic [nsfc_pkg::FIELD_W-1:0] cfg_lon_reg;
    logic [nsfc_pkg::FIELD_W-1:0] cfg_alt_reg;
    logic [nsfc_pkg::FIELD_W-1:0] cfg_expect_reg;

    nsfc_pkg::parse_state_t       state_reg;
    nsfc_pkg::parse_state_t       state_next;
    logic [7:0]                   xor_reg;
    logic [7:0]                   xor_next;
    logic [nsfc_pkg::FIELD_W-1:0] field_reg;
    logic [nsfc_pkg::FIELD_W-1:0] field_next;
    logic [3:0]                   hi_reg;
    logic [3:0]                   hi_next;
    logic                         bad_reg;
    logic                         bad_next;

    logic                         res_valid_reg;
    logic                         res_valid_next;
    nsfc_pkg::result_t            res_reg;
    nsfc_pkg::result_t            res_next;
    logic                         res_load;
    logic [7:0]                   rx_sum;
    logic                         bad_now;

    assign rx_sum  = {hi_reg, pop_tok.hex_val};
    assign bad_now = bad_reg || !pop_tok.hex_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_time_reg   <= nsfc_pkg::RST_TIME;
            cfg_lat_reg    <= nsfc_pkg::RST_LAT;
            cfg_lon_reg    <= nsfc_pkg::RST_LON;
            cfg_alt_reg    <= nsfc_pkg::RST_ALT;
            cfg_expect_reg <= nsfc_pkg::RST_EXPECT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nsfc_pkg::CFG_TIME:   cfg_time_reg   <= cfg_data;
                nsfc_pkg::CFG_LAT:    cfg_lat_reg    <= cfg_data;
                nsfc_pkg::CFG_LON:    cfg_lon_reg    <= cfg_data;
                nsfc_pkg::CFG_ALT:    cfg_alt_reg    <= cfg_data;
                nsfc_pkg::CFG_EXPECT: cfg_expect_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pop        = !q_stat.empty && (!res_valid_reg || res_chan.ready);
        state_next = state_reg;
        xor_next   = xor_reg;
        field_next = field_reg;
        hi_next    = hi_reg;
        bad_next   = bad_reg;
        res_load   = 1'b0;
        res_next   = '0;

        if (pop)
        begin
            if (pop_tok.kind == nsfc_pkg::TOK_DOLLAR)
            begin
                state_next = nsfc_pkg::ST_BODY;
                xor_next   = 8'd0;
                field_next = nsfc_pkg::FIELD_FIRST;
                hi_next    = 4'd0;
                bad_next   = 1'b0;
            end
            else
            begin
                unique case (state_reg)
                    nsfc_pkg::ST_IDLE:
                    begin
                    end
                    nsfc_pkg::ST_BODY:
                    begin
                        if (pop_tok.kind == nsfc_pkg::TOK_STAR)
                        begin
                            state_next = nsfc_pkg::ST_CK_HI;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ pop_tok.data;
                            if (pop_tok.kind == nsfc_pkg::TOK_COMMA)
                            begin
                                if (field_reg != nsfc_pkg::FIELD_MAX)
                                begin
                                    field_next = field_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                res_next.result_kind = nsfc_pkg::RES_CHAR;
                                res_next.field_char  = pop_tok.data;
                                priority if (cfg_time_reg == field_reg)
                                begin
                                    res_load          = 1'b1;
                                    res_next.field_id = nsfc_pkg::FID_TIME;
                                end
                                else if (cfg_lat_reg == field_reg)
                                begin
                                    res_load          = 1'b1;
                                    res_next.field_id = nsfc_pkg::FID_LAT;
                                end
                                else if (cfg_lon_reg == field_reg)
                                begin
                                    res_load          = 1'b1;
                                    res_next.field_id = nsfc_pkg::FID_LON;
                                end
                                else if (cfg_alt_reg == field_reg)
                                begin
                                    res_load          = 1'b1;
                                    res_next.field_id = nsfc_pkg::FID_ALT;
                                end
                                else
                                begin
                                    res_load = 1'b0;
                                end
                            end
                        end
                    end
                    nsfc_pkg::ST_CK_HI:
                    begin
                        hi_next    = pop_tok.hex_val;
                        bad_next   = bad_now;
                        state_next = nsfc_pkg::ST_CK_LO;
                    end
                    nsfc_pkg::ST_CK_LO:
                    begin
                        res_load                   = 1'b1;
                        res_next.result_kind       = nsfc_pkg::RES_STATUS;
                        res_next.checksum_ok       = !bad_now && (rx_sum == xor_reg);
                        res_next.computed_checksum = xor_reg;
                        res_next.received_checksum = rx_sum;
                        res_next.field_count       = field_reg;
                        res_next.count_ok          = (field_reg == cfg_expect_reg);
                        bad_next                   = bad_now;
                        state_next                 = nsfc_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = nsfc_pkg::ST_IDLE;
                    end
                endcase
            end
        end

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_chan.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsfc_pkg::ST_IDLE;
            xor_reg       <= 8'd0;
            field_reg     <= '0;
            hi_reg        <= 4'd0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            xor_reg       <= xor_next;
            field_reg     <= field_next;
            hi_reg        <= hi_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_chan.valid             = res_valid_reg;
    assign res_chan.result_kind       = res_reg.result_kind;
    assign res_chan.field_id          = res_reg.field_id;
    assign res_chan.field_char        = res_reg.field_char;
    assign res_chan.checksum_ok       = res_reg.checksum_ok;
    assign res_chan.computed_checksum = res_reg.computed_checksum;
    assign res_chan.received_checksum = res_reg.received_checksum;
    assign res_chan.field_count       = res_reg.field_count;
    assign res_chan.count_ok          = res_reg.count_ok;

endmodule

// File: src/nmea_sentence_field_checksum_parser.sv
// Top level of the NMEA sentence field and checksum parser.
// The block takes one sentence byte per transfer on rx_chan. A '$' opens a
// sentence; characters of the four selected fields come out on res_chan as
// character results tagged with their field, and the second checksum digit
// after '*' yields one status result with both checksums and the field count.
// Bytes outside a sentence and separators produce no result.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// A write to an index past the list is ignored. A byte is classified in the
// front end and written into a two-entry queue; the parser takes it from the
// queue once the output register is free and registers its result there.
// Throughput is one byte per cycle while the receiver keeps ready high. When
// the receiver holds ready low, the output register keeps its result, the
// parser stops, and the queue takes at most two more bytes before rx_chan
// ready drops. Reset restores the register defaults, empties the queue and
// output register and returns the parser to idle outside any sentence.
module nmea_sentence_field_checksum_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    nsfc_rx_if.sink                         rx_chan,
    nsfc_res_if.source                      res_chan,
    input  logic                            cfg_we,
    input  logic [nsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    nsfc_pkg::q_status_t q_stat;
    nsfc_pkg::token_t    push_tok;
    nsfc_pkg::token_t    pop_tok;
    logic                push;
    logic                pop;

    nsfc_front u_front (
        .rx_chan  (rx_chan),
        .q_stat   (q_stat),
        .push     (push),
        .push_tok (push_tok)
    );

    nsfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .q_stat   (q_stat)
    );

    nsfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .pop_tok   (pop_tok),
        .pop       (pop),
        .res_chan  (res_chan)
    );

endmodule

// File: src/nsfc_checker.sv
// Port-level assertions for the parser and the bind that attaches them.
module nsfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       result_kind,
    input logic [1:0] field_id,
    input logic [7:0] field_char,
    input logic       checksum_ok,
    input logic [7:0] computed_checksum,
    input logic [7:0] received_checksum,
    input logic [4:0] field_count,
    input logic       count_ok
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before its transfer");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == nsfc_pkg::RES_STATUS
            |-> field_id == nsfc_pkg::FID_TIME && field_char == 8'd0)
        else $error("status result carries character data");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == nsfc_pkg::RES_CHAR
            |-> !checksum_ok && computed_checksum == 8'd0 && received_checksum == 8'd0
                && field_count == 5'd0 && !count_ok)
        else $error("character result carries status data");

    a_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == nsfc_pkg::RES_STATUS && checksum_ok
            |-> computed_checksum == received_checksum)
        else $error("checksum reported good on differing sums");

endmodule

bind nmea_sentence_field_checksum_parser nsfc_checker u_nsfc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_chan.valid),
    .res_ready         (res_chan.ready),
    .result_kind       (res_chan.result_kind),
    .field_id          (res_chan.field_id),
    .field_char        (res_chan.field_char),
    .checksum_ok       (res_chan.checksum_ok),
    .computed_checksum (res_chan.computed_checksum),
    .received_checksum (res_chan.received_checksum),
    .field_count       (res_chan.field_count),
    .count_ok          (res_chan.count_ok)
);
